/* sv/lsa_pkg.sv */
package lsa_pkg;

    // Default table depth and the fixed width of the reported slot index.
    localparam int SLOTS_DEFAULT = 512;
    localparam int SLOT_W        = 9;

    localparam logic [15:0] MIN_LIFE_RESET = 16'd25;

    // Item kinds.
    localparam logic [1:0] KIND_SET_TIME = 2'd0;
    localparam logic [1:0] KIND_ALLOC    = 2'd1;
    localparam logic [1:0] KIND_CLEAR    = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] time_ms;
        logic [15:0] owner_id;
        logic [2:0]  prim_type;
        logic        forever_req;
        logic [23:0] lifetime_ms;
    } lsa_in_t;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] slot;
    } lsa_out_t;

    // One table entry as it sits in the slot memory.
    typedef struct packed {
        logic [2:0]  prim_type;
        logic [15:0] owner;
        logic        forever_mark;
        logic [31:0] expiry;
    } lsa_entry_t;

endpackage

/* sv/lsa_slot_ram.sv */
module lsa_slot_ram #(
    parameter int SLOTS = lsa_pkg::SLOTS_DEFAULT,
    parameter int AW    = $clog2(SLOTS)
) (
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  lsa_pkg::lsa_entry_t wdata,
    input  logic [AW-1:0]      raddr,
    output lsa_pkg::lsa_entry_t rdata
);
    import lsa_pkg::*;

    lsa_entry_t mem [SLOTS];
    lsa_entry_t rdata_reg;

    // One write port, one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/lsa_match.sv */
module lsa_match (
    input  lsa_pkg::lsa_entry_t entry,
    input  logic [15:0]         owner_id,
    input  logic [31:0]         now_ms,
    output logic                free
);
    import lsa_pkg::*;

    logic is_empty;
    logic is_expired;
    logic same_owner;

    // A slot is usable when empty, expired, or already held by this nonzero owner.
    assign is_empty   = (entry.prim_type == 3'd0);
    assign is_expired = !entry.forever_mark && (entry.expiry < now_ms);
    assign same_owner = (owner_id != 16'd0) && (entry.owner == owner_id);
    assign free       = is_empty || is_expired || same_owner;

endmodule

/* sv/lifetime_slot_allocator_core.sv */
// Lifetime slot allocator core.
//
// Items enter on the command channel: an item transfer happens at a rising
// edge where start is high and busy is low. Every item gives exactly one
// result, shown on result for one cycle with result_valid high; the receiver
// cannot stall, so each result is taken in the cycle it appears.
// A set-time item (or an unused kind) returns its result in the cycle after
// the transfer and leaves the block ready at once.
// An allocation scans the slot memory one entry per cycle through its single
// read port; a hit goes to a write state that stores the entry and gives the
// grant, and a full table gives its result when the last slot fails to match.
// A clear-all item sweeps the memory one entry per cycle and returns its
// result as the last entry is zeroed.
// For every kind the next item can transfer at the same edge that takes the
// result, so no item is taken before the result of the one in front of it.
// After reset the same clearing pass runs over the whole table with busy high.
// The minimum lifetime register is written on the cfg channel whenever
// cfg_valid and cfg_ready are high; cfg_ready is always high.
module lifetime_slot_allocator_core #(
    parameter int SLOTS = lsa_pkg::SLOTS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lsa_pkg::lsa_in_t  item,
    output logic              result_valid,
    output lsa_pkg::lsa_out_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data
);
    import lsa_pkg::*;

    localparam int          AW   = $clog2(SLOTS);
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          clear_pend_reg, clear_pend_next;
    logic [AW-1:0] scan_addr_reg, scan_addr_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [AW-1:0] chk_addr_reg, chk_addr_next;
    logic [AW-1:0] hit_addr_reg, hit_addr_next;
    logic [31:0]   now_reg, now_next;
    logic [15:0]   min_life_reg, min_life_next;
    lsa_in_t       item_reg, item_next;
    logic          res_valid_reg, res_valid_next;
    lsa_out_t      res_reg, res_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    lsa_entry_t    ram_wdata;
    lsa_entry_t    ram_rdata;
    logic          slot_free;

    logic [23:0]   span;
    logic [32:0]   expiry_sum;
    logic [31:0]   expiry_sat;
    logic [31:0]   hit_addr_ext;

    lsa_slot_ram #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_addr_reg),
        .rdata (ram_rdata)
    );

    // The compare unit looks at the one entry that the memory returned this cycle.
    lsa_match u_match (
        .entry    (ram_rdata),
        .owner_id (item_reg.owner_id),
        .now_ms   (now_reg),
        .free     (slot_free)
    );

    // Expiry of a timed slot: now plus the longer of the two lifetimes,
    // pinned at the top of the 32-bit range.
    assign span = (item_reg.lifetime_ms > {8'd0, min_life_reg})
                ? item_reg.lifetime_ms : {8'd0, min_life_reg};
    assign expiry_sum   = {1'b0, now_reg} + {9'd0, span};
    assign expiry_sat   = expiry_sum[32] ? 32'hFFFF_FFFF : expiry_sum[31:0];
    assign hit_addr_ext = 32'(hit_addr_reg);

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        clear_pend_next = clear_pend_reg;
        scan_addr_next  = scan_addr_reg;
        chk_valid_next  = chk_valid_reg;
        chk_addr_next   = chk_addr_reg;
        hit_addr_next   = hit_addr_reg;
        now_next        = now_reg;
        min_life_next   = min_life_reg;
        item_next       = item_reg;
        res_valid_next  = 1'b0;
        res_next        = res_reg;
        ram_we          = 1'b0;
        ram_waddr       = clr_addr_reg;
        ram_wdata       = '0;

        if (cfg_valid && cfg_ready)
        begin
            min_life_next = cfg_data;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // Zero one entry per cycle; a zero type marks the slot empty.
                ram_we = 1'b1;
                if (clr_addr_reg == LAST)
                begin
                    clr_addr_next = '0;
                    state_next    = ST_IDLE;
                    if (clear_pend_reg)
                    begin
                        res_valid_next  = 1'b1;
                        res_next        = '0;
                        clear_pend_next = 1'b0;
                    end
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    case (item.kind)
                        KIND_SET_TIME:
                        begin
                            now_next       = item.time_ms;
                            res_valid_next = 1'b1;
                            res_next       = '0;
                        end
                        KIND_ALLOC:
                        begin
                            item_next      = item;
                            scan_addr_next = '0;
                            chk_valid_next = 1'b0;
                            state_next     = ST_SCAN;
                        end
                        KIND_CLEAR:
                        begin
                            clear_pend_next = 1'b1;
                            clr_addr_next   = '0;
                            state_next      = ST_CLEAR;
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                            res_next       = '0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Reads run one address ahead of the compare; the read
                // address holds at the last slot once it gets there.
                chk_valid_next = 1'b1;
                chk_addr_next  = scan_addr_reg;
                scan_addr_next = (scan_addr_reg == LAST) ? LAST : scan_addr_reg + AW'(1);
                if (chk_valid_reg)
                begin
                    if (slot_free)
                    begin
                        hit_addr_next = chk_addr_reg;
                        state_next    = ST_WRITE;
                    end
                    else if (chk_addr_reg == LAST)
                    begin
                        // Table full: nothing is written.
                        res_valid_next = 1'b1;
                        res_next       = '0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_WRITE:
            begin
                ram_we                 = 1'b1;
                ram_waddr              = hit_addr_reg;
                ram_wdata.prim_type    = item_reg.prim_type;
                ram_wdata.owner        = item_reg.owner_id;
                ram_wdata.forever_mark = item_reg.forever_req;
                ram_wdata.expiry       = item_reg.forever_req ? 32'd0 : expiry_sat;
                res_valid_next         = 1'b1;
                res_next.granted       = 1'b1;
                res_next.slot          = hit_addr_ext[SLOT_W-1:0];
                state_next             = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state; reset starts the clearing pass over the whole table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            clear_pend_reg <= 1'b0;
            scan_addr_reg  <= '0;
            chk_valid_reg  <= 1'b0;
            now_reg        <= '0;
            min_life_reg   <= MIN_LIFE_RESET;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            clear_pend_reg <= clear_pend_next;
            scan_addr_reg  <= scan_addr_next;
            chk_valid_reg  <= chk_valid_next;
            now_reg        <= now_next;
            min_life_reg   <= min_life_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        chk_addr_reg <= chk_addr_next;
        hit_addr_reg <= hit_addr_next;
        item_reg     <= item_next;
        res_reg      <= res_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign cfg_ready    = 1'b1;

endmodule

/* sv/lsa_checker.sv */
module lsa_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input lsa_pkg::lsa_in_t  item,
    input logic              result_valid,
    input lsa_pkg::lsa_out_t result
);
    import lsa_pkg::*;

    // A set-time transfer answers in the very next cycle with no grant.
    a_set_time_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.kind == KIND_SET_TIME) |=> result_valid && !result.granted)
        else $error("set-time item did not return its result in the next cycle");

    // A refused or non-allocating result reports slot zero.
    a_no_grant_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.granted |-> result.slot == '0)
        else $error("result without grant carries a nonzero slot");

    // An allocation always goes into the scan and holds off new items.
    a_alloc_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.kind == KIND_ALLOC) |=> busy)
        else $error("allocation did not make the block busy");

    // A grant is only ever the end of a scan.
    a_grant_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.granted |-> $past(busy))
        else $error("grant appeared without a preceding scan");

    // Leaving reset starts the clearing pass.
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> busy)
        else $error("block not busy clearing after reset");

endmodule

bind lifetime_slot_allocator_core lsa_checker u_lsa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
);

/* sim/testbench.sv */
`timescale 1ns / 1ps

// Self-checking bench for the lifetime slot allocator core.
//
// A behavioral copy of the slot table lives in this module. Every item that
// the core takes on the command channel is applied to that copy at the same
// clock edge, and the grant it should produce is queued. A monitor pops the
// queue on every result strobe and compares both fields. The core can never
// hold a result back, so the monitor just samples on each rising edge.
module testbench;

    import lsa_pkg::*;

    localparam int SLOTS = SLOTS_DEFAULT;

    // The fourth kind code has no meaning in the core and must be ignored.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // A stretch this long with no transfer of any kind means the core hung.
    // The slowest legal stretch is a clearing pass or a full-table scan, so
    // this leaves plenty of margin.
    localparam int HANG_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    lsa_in_t     item;
    logic        result_valid;
    lsa_out_t    result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // Expected copy of the slot table and of the core's scalar state.
    logic [2:0]  tbl_type    [SLOTS];
    logic [15:0] tbl_owner   [SLOTS];
    logic        tbl_forever [SLOTS];
    logic [31:0] tbl_expiry  [SLOTS];
    logic [31:0] cur_time;
    logic [15:0] min_life;

    // Grants still owed by the core, oldest first.
    lsa_out_t    grant_q[$];

    int          err_count;
    int          idle_cycles;
    bit          gaps_on;

    lifetime_slot_allocator_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one accepted item to the expected table and work out the grant.
    // The scan takes the lowest slot that is empty (type 0), timed and past
    // its expiry, or already held by the same nonzero owner. A slot whose
    // expiry equals the current time is still alive.
    task automatic predict_grant(input lsa_in_t it, output lsa_out_t grant);
        int          i;
        int          hit;
        logic [31:0] span;
        logic [32:0] sum;
        grant = '0;
        case (it.kind)
            KIND_SET_TIME:
            begin
                cur_time = it.time_ms;
            end
            KIND_CLEAR:
            begin
                // The time and the minimum lifetime survive a clear.
                for (i = 0; i < SLOTS; i++)
                begin
                    tbl_type[i]    = '0;
                    tbl_owner[i]   = '0;
                    tbl_forever[i] = 1'b0;
                    tbl_expiry[i]  = '0;
                end
            end
            KIND_ALLOC:
            begin
                hit = -1;
                for (i = 0; i < SLOTS && hit < 0; i++)
                begin
                    if (tbl_type[i] == 3'd0 ||
                        (!tbl_forever[i] && tbl_expiry[i] < cur_time) ||
                        (it.owner_id != 16'd0 && tbl_owner[i] == it.owner_id))
                        hit = i;
                end
                // A full table grants nothing and leaves every slot alone.
                if (hit >= 0)
                begin
                    // Types outside 1..6 are stored exactly as given.
                    tbl_type[hit]  = it.prim_type;
                    tbl_owner[hit] = it.owner_id;
                    if (it.forever_req)
                    begin
                        tbl_forever[hit] = 1'b1;
                        tbl_expiry[hit]  = '0;
                    end
                    else
                    begin
                        span = ({8'd0, it.lifetime_ms} > {16'd0, min_life}) ?
                               {8'd0, it.lifetime_ms} : {16'd0, min_life};
                        sum  = {1'b0, cur_time} + {1'b0, span};
                        tbl_forever[hit] = 1'b0;
                        tbl_expiry[hit]  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    end
                    grant.granted = 1'b1;
                    grant.slot    = hit[SLOT_W-1:0];
                end
            end
            default:
            begin
                // The unused kind changes nothing and grants nothing.
            end
        endcase
    endtask

    // Offer one item and hold it until the core takes it. Random idle cycles
    // go in front of the item when gaps are enabled. The item transfer is the
    // first rising edge at which start is high and busy is low; busy is read
    // right after the edge, so the value seen is the one that edge sampled.
    task automatic send_item(input lsa_in_t it);
        lsa_out_t grant;
        while (gaps_on && $urandom_range(99) < 17)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_grant(it, grant);
        grant_q.push_back(grant);
    endtask

    // Stop offering items and wait until every owed grant has come back and
    // the core has dropped busy, so that the table is quiet.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (grant_q.size() != 0 || busy);
    endtask

    // Change the minimum lifetime. Only done with the core idle.
    task automatic write_min_life(input logic [15:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        min_life = value;
        cfg_valid <= 1'b0;
    endtask

    // Item builders. Fields that the kind does not use carry random values,
    // since the core must ignore them.
    function automatic lsa_in_t noise_item(input logic [1:0] kind);
        lsa_in_t it;
        it.kind        = kind;
        it.time_ms     = $urandom();
        it.owner_id    = 16'($urandom());
        it.prim_type   = 3'($urandom());
        it.forever_req = 1'($urandom());
        it.lifetime_ms = 24'($urandom());
        return it;
    endfunction

    function automatic lsa_in_t time_item(input logic [31:0] t);
        lsa_in_t it;
        it         = noise_item(KIND_SET_TIME);
        it.time_ms = t;
        return it;
    endfunction

    function automatic lsa_in_t alloc_item(input logic [15:0] owner,
                                           input logic [2:0] ptype,
                                           input logic forever_mark,
                                           input logic [23:0] life);
        lsa_in_t it;
        it             = noise_item(KIND_ALLOC);
        it.owner_id    = owner;
        it.prim_type   = ptype;
        it.forever_req = forever_mark;
        it.lifetime_ms = life;
        return it;
    endfunction

    // Fresh table after reset with the default minimum lifetime: slot order,
    // owner reuse, the no-owner rule and out-of-range types.
    task automatic test_reset_state();
        send_item(alloc_item(16'd0, 3'd1, 1'b0, 24'd0));
        send_item(alloc_item(16'd5, 3'd6, 1'b1, 24'hFFFFFF));
        send_item(alloc_item(16'd5, 3'd2, 1'b0, 24'd100));
        send_item(alloc_item(16'd0, 3'd7, 1'b0, 24'd10));
        // A stored type of zero leaves the slot looking empty.
        send_item(alloc_item(16'd0, 3'd0, 1'b1, 24'd0));
        send_item(alloc_item(16'd0, 3'd3, 1'b0, 24'd1));
        send_item(alloc_item(16'hFFFF, 3'd4, 1'b0, 24'hFFFFFF));
        send_item(alloc_item(16'hFFFF, 3'd5, 1'b1, 24'd0));
    endtask

    // Expiry edges: equal to now stays alive, one past it frees the slot,
    // and a long lifetime near the top of time saturates.
    task automatic test_time_rules();
        send_item(time_item(32'd25));
        send_item(alloc_item(16'd0, 3'd1, 1'b0, 24'd0));
        send_item(time_item(32'd26));
        send_item(alloc_item(16'd0, 3'd2, 1'b0, 24'd0));
        send_item(time_item(32'hFFFF_FFFF));
        send_item(alloc_item(16'd9, 3'd3, 1'b0, 24'hFFFFFF));
        send_item(alloc_item(16'd9, 3'd4, 1'b0, 24'd0));
        send_item(time_item(32'd0));
        send_item(alloc_item(16'd0, 3'd6, 1'b0, 24'd0));
    endtask

    // The unused kind and clear-all, then a grant from the bottom again.
    task automatic test_item_kinds();
        send_item(noise_item(KIND_UNUSED));
        send_item(noise_item(KIND_CLEAR));
        send_item(alloc_item(16'd5, 3'd1, 1'b0, 24'd50));
        send_item(noise_item(KIND_UNUSED));
        send_item(alloc_item(16'd5, 3'd2, 1'b1, 24'd0));
    endtask

    // Fill every slot, then check the full-table miss, an owner match in a
    // full table and a timed slot running out. Runs without idle gaps.
    task automatic test_full_table();
        int i;
        drain();
        gaps_on = 1'b0;
        send_item(noise_item(KIND_CLEAR));
        send_item(time_item(32'd1000));
        for (i = 0; i < SLOTS; i++)
        begin
            if (i == 100)
                send_item(alloc_item(16'd77, 3'($urandom_range(1, 6)), 1'b1, 24'd0));
            else if (i == SLOTS - 1)
                send_item(alloc_item(16'd0, 3'($urandom_range(1, 6)), 1'b0, 24'd0));
            else
                send_item(alloc_item(16'd0, 3'($urandom_range(1, 6)), 1'b1, 24'd0));
        end
        send_item(alloc_item(16'd0, 3'd1, 1'b1, 24'd0));
        send_item(alloc_item(16'd3, 3'd2, 1'b0, 24'd5));
        send_item(alloc_item(16'd77, 3'd3, 1'b0, 24'd5));
        send_item(time_item(32'd1000 + 32'(min_life) + 32'd1));
        send_item(alloc_item(16'd0, 3'd4, 1'b1, 24'd0));
        send_item(noise_item(KIND_CLEAR));
        drain();
        gaps_on = 1'b1;
    endtask

    // Random traffic shaped like real use: time creeps forward in small
    // steps, allocations come from a small pool of owners with short
    // lifetimes so that slots expire and get reused, and a clear now and
    // then keeps the table shallow. Full-range values are mixed in so that
    // every field bit moves.
    task automatic test_random_phase(input int count, input logic [15:0] life_floor);
        int          n;
        int          pick;
        logic [15:0] owner;
        logic [2:0]  ptype;
        logic [23:0] life;
        write_min_life(life_floor);
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
                send_item(time_item($urandom()));
            else if (pick < 26)
                send_item(time_item(cur_time + 32'($urandom_range(0, 300))));
            else if (pick < 28)
                send_item(time_item(cur_time - 32'($urandom_range(0, 50))));
            else if (pick < 31)
                send_item(noise_item(KIND_CLEAR));
            else if (pick < 33)
                send_item(noise_item(KIND_UNUSED));
            else
            begin
                case ($urandom_range(4))
                    0, 1:    owner = 16'd0;
                    2, 3:    owner = 16'($urandom_range(1, 8));
                    default: owner = 16'($urandom());
                endcase
                if ($urandom_range(9) < 8)
                    ptype = 3'($urandom_range(1, 6));
                else
                    ptype = $urandom_range(1) ? 3'd7 : 3'd0;
                if ($urandom_range(9) < 7)
                    life = 24'($urandom_range(0, 200));
                else
                    life = 24'($urandom());
                send_item(alloc_item(owner, ptype, $urandom_range(4) == 0, life));
            end
        end
    endtask

    // Result monitor: every strobe must match the oldest owed grant.
    always @(posedge clk)
    begin
        lsa_out_t want;
        if (rst_n && result_valid)
        begin
            if (grant_q.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result, expected none, actual granted=%0d slot=%0d",
                         $time, result.granted, result.slot);
            end
            else
            begin
                want = grant_q.pop_front();
                if (result.granted !== want.granted)
                begin
                    err_count++;
                    $display("%0t: granted expected %0d actual %0d",
                             $time, want.granted, result.granted);
                end
                if (result.slot !== want.slot)
                begin
                    err_count++;
                    $display("%0t: slot expected %0d actual %0d",
                             $time, want.slot, result.slot);
                end
            end
        end
    end

    // Hang detector: any item, result or register transfer resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= HANG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int i;
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        err_count   = 0;
        idle_cycles = 0;
        gaps_on     = 1'b1;
        cur_time    = '0;
        min_life    = MIN_LIFE_RESET;
        for (i = 0; i < SLOTS; i++)
        begin
            tbl_type[i]    = '0;
            tbl_owner[i]   = '0;
            tbl_forever[i] = 1'b0;
            tbl_expiry[i]  = '0;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // The first items meet the core still in its post-reset clearing
        // pass; send_item simply waits for busy to fall.
        test_reset_state();
        test_time_rules();
        test_item_kinds();
        test_full_table();
        test_random_phase(8, 16'd0);
        test_random_phase(8, 16'hFFFF);
        test_random_phase(8, 16'($urandom()));
        test_random_phase(8, MIN_LIFE_RESET);

        // Let every owed grant arrive, then watch a while longer for strays.
        drain();
        repeat (SLOTS + 10) @(posedge clk);
        if (err_count == 0 && grant_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
